>>> src/cpt_pkg.sv
package cpt_pkg;

   // Field and datapath widths
   localparam int COORD_W = 16;              // Q3.13 coordinate
   localparam int DIFF_W  = COORD_W + 1;     // difference of two coordinates
   localparam int PROD_W  = 2 * DIFF_W;      // product of two differences
   localparam int DOT_W   = PROD_W + 2;      // sum of three products
   localparam int WIDE_W  = 2 * DOT_W;       // product of two dot products
   localparam int DIV_W   = WIDE_W + 2;      // divider operands, sum of three wide terms
   localparam int Q_W     = 16;              // Q1.15 weight
   localparam int Q_FRAC  = 15;

   localparam logic [Q_W-1:0] ONE_Q15 = 16'h8000;

   typedef enum logic [2:0] {
      RGN_A, RGN_B, RGN_AB, RGN_C, RGN_AC, RGN_BC, RGN_FACE, RGN_DEGEN
   } region_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] query_x;
      logic signed [COORD_W-1:0] query_y;
      logic signed [COORD_W-1:0] query_z;
      logic signed [COORD_W-1:0] corner_a_x;
      logic signed [COORD_W-1:0] corner_a_y;
      logic signed [COORD_W-1:0] corner_a_z;
      logic signed [COORD_W-1:0] corner_b_x;
      logic signed [COORD_W-1:0] corner_b_y;
      logic signed [COORD_W-1:0] corner_b_z;
      logic signed [COORD_W-1:0] corner_c_x;
      logic signed [COORD_W-1:0] corner_c_y;
      logic signed [COORD_W-1:0] corner_c_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] nearest_x;
      logic signed [COORD_W-1:0] nearest_y;
      logic signed [COORD_W-1:0] nearest_z;
      logic [Q_W-1:0]            weight_first;
      logic [Q_W-1:0]            weight_second;
      logic [Q_W-1:0]            weight_third;
      logic [2:0]                region;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } cvec_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] x;
      logic signed [DIFF_W-1:0] y;
      logic signed [DIFF_W-1:0] z;
   } dvec_type;

   // What rides along the divider: region, base corner and edge vectors
   typedef struct packed {
      region_type region;
      cvec_type   base;
      dvec_type   e1;
      dvec_type   e2;
   } side_type;

   typedef struct packed {
      logic signed [DIV_W-1:0] num1;
      logic signed [DIV_W-1:0] den1;
      logic signed [DIV_W-1:0] num2;
      logic signed [DIV_W-1:0] den2;
      side_type                side;
   } div_in_type;

   typedef struct packed {
      logic [Q_W-1:0] q1;
      logic [Q_W-1:0] q2;
      side_type       side;
   } div_out_type;

endpackage

>>> src/cpt_div.sv
module cpt_div
   import cpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  div_in_type  in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output div_out_type out_data
);

   // 15 quotient bits plus one rounding step
   localparam int NSTEP = Q_FRAC + 1;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [DIV_W-1:0] den;
      logic [Q_W-1:0]   q;
      logic             done;
   } lane_type;

   // Nonpositive operands give 0, a ratio of one or more gives 1.0
   function automatic lane_type lane_prep(logic signed [DIV_W-1:0] num,
                                          logic signed [DIV_W-1:0] den);
      lane_type s;
      s.rem  = num;
      s.den  = den;
      s.q    = '0;
      s.done = 1'b0;
      if (num[DIV_W-1] || num == '0 || den[DIV_W-1] || den == '0) begin
         s.done = 1'b1;
      end else if (num >= den) begin
         s.done = 1'b1;
         s.q    = ONE_Q15;
      end
      return s;
   endfunction

   // One restoring step; the last step rounds half up
   function automatic lane_type lane_step(lane_type s, logic last);
      lane_type         r;
      logic [DIV_W-1:0] dbl;
      logic             ge;
      r   = s;
      dbl = {s.rem[DIV_W-2:0], 1'b0};
      ge  = dbl >= s.den;
      if (!s.done) begin
         if (last) begin
            r.q = s.q + Q_W'(ge);
         end else begin
            r.q   = {s.q[Q_W-2:0], ge};
            r.rem = ge ? dbl - s.den : dbl;
         end
      end
      return r;
   endfunction

   lane_type       l1_ff [0:NSTEP];
   lane_type       l2_ff [0:NSTEP];
   side_type       sd_ff [0:NSTEP];
   logic [NSTEP:0] vld_ff;
   logic [NSTEP:0] en;

   // Stage advances when empty or when the next stage takes its item
   always_comb begin
      en[NSTEP] = !vld_ff[NSTEP] || out_ready;
      for (int k = NSTEP - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k <= NSTEP; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Divider stages
   always_ff @(posedge clock) begin
      if (en[0]) begin
         l1_ff[0] <= lane_prep(in_data.num1, in_data.den1);
         l2_ff[0] <= lane_prep(in_data.num2, in_data.den2);
         sd_ff[0] <= in_data.side;
      end
      for (int k = 1; k <= NSTEP; k++) begin
         if (en[k]) begin
            l1_ff[k] <= lane_step(l1_ff[k-1], k == NSTEP);
            l2_ff[k] <= lane_step(l2_ff[k-1], k == NSTEP);
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   assign out_valid     = vld_ff[NSTEP];
   assign out_data.q1   = l1_ff[NSTEP].q;
   assign out_data.q2   = l2_ff[NSTEP].q;
   assign out_data.side = sd_ff[NSTEP];

   a_q_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_data.q1 <= ONE_Q15 && out_data.q2 <= ONE_Q15)
      else $error("quotient above 1.0");

   a_q2_face_only: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_data.side.region != RGN_FACE |-> out_data.q2 == '0)
      else $error("second quotient set outside face region");

endmodule

>>> src/closest_point_on_triangle.sv
// Closest point on a triangle with Voronoi region classification.
// Input channel req_*: one query point and three corners per transfer, all
// signed Q3.13. Result channel rsp_*: the closest point, barycentric weights
// in Q1.15 and a region code, one result for every accepted query.
// Throughput: one query per cycle while the result side does not stall. The
// datapath is a 25-stage pipeline: six stages of edge differences, dot
// products and wide cross terms split into 18-bit partial products, 17 stages
// of a pair of restoring dividers (prep, then one quotient bit per stage, then
// rounding), and two stages that scale the edge vectors and round.
// Reset clears all valid bits; data registers are not reset.
// When the receiver holds rsp_ready low the result stays on rsp_data and
// the stages behind it keep filling their empty slots; req_ready drops only
// once every stage holds a query. Nothing is lost or repeated.
// Degenerate triangles (zero cross product) return corner A, weight 1.0 on
// A and region code 7.
module closest_point_on_triangle
   import cpt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int HALF_W  = DOT_W / 2;
   localparam int LL_W    = 2 * HALF_W;
   localparam int LH_W    = 2 * HALF_W + 1;
   localparam int CROSS_W = PROD_W + 1;
   localparam int SUM_W   = PROD_W + 2;

   localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(16384);
   localparam logic signed [SUM_W-1:0] SAT_MAX  = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] SAT_MIN  = -SUM_W'(32768);

   typedef struct packed {
      cvec_type a;
      cvec_type b;
      cvec_type c;
      dvec_type ab;
      dvec_type ac;
      dvec_type bc;
   } geom_type;

   typedef struct packed {
      logic        [LL_W-1:0] ll;
      logic signed [LH_W-1:0] lh;
      logic signed [LH_W-1:0] hl;
      logic signed [LL_W-1:0] hh;
   } pp_type;

   function automatic logic signed [DIFF_W-1:0] dcomp(dvec_type v, logic [1:0] i);
      logic signed [DIFF_W-1:0] r;
      case (i)
         2'd0:    r = v.x;
         2'd1:    r = v.y;
         default: r = v.z;
      endcase
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] ccomp(cvec_type v, logic [1:0] i);
      logic signed [COORD_W-1:0] r;
      case (i)
         2'd0:    r = v.x;
         2'd1:    r = v.y;
         default: r = v.z;
      endcase
      return r;
   endfunction

   // 36x36 signed product as four 18-bit partial products
   function automatic pp_type pp_split(logic signed [DOT_W-1:0] a,
                                       logic signed [DOT_W-1:0] b);
      pp_type                   p;
      logic        [HALF_W-1:0] al;
      logic        [HALF_W-1:0] bl;
      logic signed [HALF_W-1:0] ah;
      logic signed [HALF_W-1:0] bh;
      al   = a[HALF_W-1:0];
      bl   = b[HALF_W-1:0];
      ah   = a[DOT_W-1:HALF_W];
      bh   = b[DOT_W-1:HALF_W];
      p.ll = LL_W'(al) * LL_W'(bl);
      p.lh = LH_W'($signed({1'b0, al})) * LH_W'(bh);
      p.hl = LH_W'(ah) * LH_W'($signed({1'b0, bl}));
      p.hh = LL_W'(ah) * LL_W'(bh);
      return p;
   endfunction

   function automatic logic signed [WIDE_W-1:0] pp_join(pp_type p);
      return $signed(WIDE_W'(p.ll)) + (WIDE_W'(p.lh) <<< HALF_W)
           + (WIDE_W'(p.hl) <<< HALF_W) + (WIDE_W'(p.hh) <<< (2 * HALF_W));
   endfunction

   function automatic logic wide_le0(logic signed [WIDE_W-1:0] x);
      return x[WIDE_W-1] || x == '0;
   endfunction

   // ---------------------------------------------------------------
   // Front pipeline control
   // ---------------------------------------------------------------
   logic [5:0] f_vld_ff;
   logic [5:0] f_en;
   logic [1:0] b_vld_ff;
   logic [1:0] b_en;
   logic       div_in_ready;
   logic       div_out_valid;
   div_in_type  div_in;
   div_out_type div_out;

   always_comb begin
      b_en[1] = !b_vld_ff[1] || rsp_ready;
      b_en[0] = !b_vld_ff[0] || b_en[1];
      f_en[5] = !f_vld_ff[5] || div_in_ready;
      for (int k = 4; k >= 0; k--) begin
         f_en[k] = !f_vld_ff[k] || f_en[k+1];
      end
   end

   assign req_ready = f_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= '0;
         b_vld_ff <= '0;
      end else begin
         if (f_en[0]) f_vld_ff[0] <= req_valid;
         for (int k = 1; k < 6; k++) begin
            if (f_en[k]) f_vld_ff[k] <= f_vld_ff[k-1];
         end
         if (b_en[0]) b_vld_ff[0] <= div_out_valid;
         if (b_en[1]) b_vld_ff[1] <= b_vld_ff[0];
      end
   end

   // ---------------------------------------------------------------
   // F0: edge vectors and point offsets
   // ---------------------------------------------------------------
   geom_type                 g0;
   logic signed [COORD_W-1:0] pin [3];
   logic signed [COORD_W-1:0] crn [3][3];

   always_comb begin
      pin[0]    = req_data.query_x;
      pin[1]    = req_data.query_y;
      pin[2]    = req_data.query_z;
      crn[0][0] = req_data.corner_a_x;
      crn[0][1] = req_data.corner_a_y;
      crn[0][2] = req_data.corner_a_z;
      crn[1][0] = req_data.corner_b_x;
      crn[1][1] = req_data.corner_b_y;
      crn[1][2] = req_data.corner_b_z;
      crn[2][0] = req_data.corner_c_x;
      crn[2][1] = req_data.corner_c_y;
      crn[2][2] = req_data.corner_c_z;
      g0.a    = {crn[0][0], crn[0][1], crn[0][2]};
      g0.b    = {crn[1][0], crn[1][1], crn[1][2]};
      g0.c    = {crn[2][0], crn[2][1], crn[2][2]};
      g0.ab.x = DIFF_W'(crn[1][0]) - DIFF_W'(crn[0][0]);
      g0.ab.y = DIFF_W'(crn[1][1]) - DIFF_W'(crn[0][1]);
      g0.ab.z = DIFF_W'(crn[1][2]) - DIFF_W'(crn[0][2]);
      g0.ac.x = DIFF_W'(crn[2][0]) - DIFF_W'(crn[0][0]);
      g0.ac.y = DIFF_W'(crn[2][1]) - DIFF_W'(crn[0][1]);
      g0.ac.z = DIFF_W'(crn[2][2]) - DIFF_W'(crn[0][2]);
      g0.bc.x = DIFF_W'(crn[2][0]) - DIFF_W'(crn[1][0]);
      g0.bc.y = DIFF_W'(crn[2][1]) - DIFF_W'(crn[1][1]);
      g0.bc.z = DIFF_W'(crn[2][2]) - DIFF_W'(crn[1][2]);
   end

   geom_type                  geo_ff [0:5];
   logic signed [DIFF_W-1:0]  pd_ff  [3][3];
   logic signed [PROD_W-1:0]  dp_ff  [6][3];
   logic signed [PROD_W-1:0]  xp_ff  [3][2];
   logic signed [DOT_W-1:0]   dd_ff  [2:5][6];
   logic [5:2]                dg_ff;
   pp_type                    pp_ff  [6];
   logic signed [WIDE_W-1:0]  prod_ff [6];
   logic signed [WIDE_W-1:0]  va_ff;
   logic signed [WIDE_W-1:0]  vb_ff;
   logic signed [WIDE_W-1:0]  vc_ff;
   logic signed [CROSS_W-1:0] crs [3];

   // Cross product components, for the degenerate test
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         crs[i] = CROSS_W'(xp_ff[i][0]) - CROSS_W'(xp_ff[i][1]);
      end
   end

   // F0 .. F5 datapath
   always_ff @(posedge clock) begin
      // F0
      if (f_en[0]) begin
         geo_ff[0] <= g0;
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               pd_ff[k][i] <= DIFF_W'(pin[i]) - DIFF_W'(crn[k][i]);
            end
         end
      end
      for (int k = 1; k < 6; k++) begin
         if (f_en[k]) geo_ff[k] <= geo_ff[k-1];
      end
      // F1: dot and cross products
      if (f_en[1]) begin
         for (int j = 0; j < 6; j++) begin
            for (int i = 0; i < 3; i++) begin
               dp_ff[j][i] <= PROD_W'(dcomp(j[0] ? geo_ff[0].ac : geo_ff[0].ab, 2'(i)))
                            * PROD_W'(pd_ff[j>>1][i]);
            end
         end
         xp_ff[0][0] <= PROD_W'(geo_ff[0].ab.y) * PROD_W'(geo_ff[0].ac.z);
         xp_ff[0][1] <= PROD_W'(geo_ff[0].ab.z) * PROD_W'(geo_ff[0].ac.y);
         xp_ff[1][0] <= PROD_W'(geo_ff[0].ab.z) * PROD_W'(geo_ff[0].ac.x);
         xp_ff[1][1] <= PROD_W'(geo_ff[0].ab.x) * PROD_W'(geo_ff[0].ac.z);
         xp_ff[2][0] <= PROD_W'(geo_ff[0].ab.x) * PROD_W'(geo_ff[0].ac.y);
         xp_ff[2][1] <= PROD_W'(geo_ff[0].ab.y) * PROD_W'(geo_ff[0].ac.x);
      end
      // F2: d1..d6 and degenerate flag
      if (f_en[2]) begin
         for (int j = 0; j < 6; j++) begin
            dd_ff[2][j] <= DOT_W'(dp_ff[j][0]) + DOT_W'(dp_ff[j][1]) + DOT_W'(dp_ff[j][2]);
         end
         dg_ff[2] <= crs[0] == '0 && crs[1] == '0 && crs[2] == '0;
      end
      for (int k = 3; k < 6; k++) begin
         if (f_en[k]) begin
            dd_ff[k] <= dd_ff[k-1];
            dg_ff[k] <= dg_ff[k-1];
         end
      end
      // F3: partial products of d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
      if (f_en[3]) begin
         pp_ff[0] <= pp_split(dd_ff[2][0], dd_ff[2][3]);
         pp_ff[1] <= pp_split(dd_ff[2][2], dd_ff[2][1]);
         pp_ff[2] <= pp_split(dd_ff[2][4], dd_ff[2][1]);
         pp_ff[3] <= pp_split(dd_ff[2][0], dd_ff[2][5]);
         pp_ff[4] <= pp_split(dd_ff[2][2], dd_ff[2][5]);
         pp_ff[5] <= pp_split(dd_ff[2][4], dd_ff[2][3]);
      end
      // F4: full products
      if (f_en[4]) begin
         for (int j = 0; j < 6; j++) begin
            prod_ff[j] <= pp_join(pp_ff[j]);
         end
      end
      // F5: va, vb, vc
      if (f_en[5]) begin
         vc_ff <= prod_ff[0] - prod_ff[1];
         vb_ff <= prod_ff[2] - prod_ff[3];
         va_ff <= prod_ff[4] - prod_ff[5];
      end
   end

   // ---------------------------------------------------------------
   // Region tests, in order A, B, AB, C, AC, BC, face
   // ---------------------------------------------------------------
   logic signed [DOT_W-1:0] d1, d2, d3, d4, d5, d6;
   logic signed [DIV_W-1:0] e43, e56;
   geom_type                gs;

   always_comb begin
      d1  = dd_ff[5][0];
      d2  = dd_ff[5][1];
      d3  = dd_ff[5][2];
      d4  = dd_ff[5][3];
      d5  = dd_ff[5][4];
      d6  = dd_ff[5][5];
      gs  = geo_ff[5];
      e43 = DIV_W'(d4) - DIV_W'(d3);
      e56 = DIV_W'(d5) - DIV_W'(d6);
      // zero numerators give zero quotients
      div_in             = '0;
      div_in.side.base   = gs.a;
      div_in.side.region = RGN_DEGEN;
      if (dg_ff[5]) begin
         div_in.side.region = RGN_DEGEN;
      end else if (d1 <= 0 && d2 <= 0) begin
         div_in.side.region = RGN_A;
      end else if (d3 >= 0 && d4 <= d3) begin
         div_in.side.region = RGN_B;
         div_in.side.base   = gs.b;
      end else if (wide_le0(vc_ff) && d1 >= 0 && d3 <= 0) begin
         div_in.side.region = RGN_AB;
         div_in.side.e1     = gs.ab;
         div_in.num1        = DIV_W'(d1);
         div_in.den1        = DIV_W'(d1) - DIV_W'(d3);
      end else if (d6 >= 0 && d5 <= d6) begin
         div_in.side.region = RGN_C;
         div_in.side.base   = gs.c;
      end else if (wide_le0(vb_ff) && d2 >= 0 && d6 <= 0) begin
         div_in.side.region = RGN_AC;
         div_in.side.e1     = gs.ac;
         div_in.num1        = DIV_W'(d2);
         div_in.den1        = DIV_W'(d2) - DIV_W'(d6);
      end else if (wide_le0(va_ff) && !e43[DIV_W-1] && !e56[DIV_W-1]) begin
         div_in.side.region = RGN_BC;
         div_in.side.base   = gs.b;
         div_in.side.e1     = gs.bc;
         div_in.num1        = e43;
         div_in.den1        = e43 + e56;
      end else begin
         div_in.side.region = RGN_FACE;
         div_in.side.e1     = gs.ab;
         div_in.side.e2     = gs.ac;
         div_in.num1        = DIV_W'(vb_ff);
         div_in.num2        = DIV_W'(vc_ff);
         div_in.den1        = DIV_W'(va_ff) + DIV_W'(vb_ff) + DIV_W'(vc_ff);
         div_in.den2        = div_in.den1;
      end
   end

   cpt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_vld_ff[5]),
      .in_ready  (div_in_ready),
      .in_data   (div_in),
      .out_valid (div_out_valid),
      .out_ready (b_en[0]),
      .out_data  (div_out)
   );

   // ---------------------------------------------------------------
   // B0: weights and edge scaling
   // ---------------------------------------------------------------
   logic signed [PROD_W-1:0] m1_ff [3];
   logic signed [PROD_W-1:0] m2_ff [3];
   cvec_type                 bs_ff;
   region_type               rg_ff;
   logic [Q_W-1:0]           wu_ff, wv_ff, ww_ff;
   logic [Q_W-1:0]           wu, wv, ww;
   logic [Q_W:0]             qs;

   always_comb begin
      qs = (Q_W+1)'(div_out.q1) + (Q_W+1)'(div_out.q2);
      wu = '0;
      wv = '0;
      ww = '0;
      case (div_out.side.region)
         RGN_B: wv = ONE_Q15;
         RGN_C: ww = ONE_Q15;
         RGN_AB: begin
            wv = div_out.q1;
            wu = ONE_Q15 - div_out.q1;
         end
         RGN_AC: begin
            ww = div_out.q1;
            wu = ONE_Q15 - div_out.q1;
         end
         RGN_BC: begin
            ww = div_out.q1;
            wv = ONE_Q15 - div_out.q1;
         end
         RGN_FACE: begin
            wv = div_out.q1;
            ww = div_out.q2;
            wu = (qs >= (Q_W+1)'(ONE_Q15)) ? '0 : Q_W'((Q_W+1)'(ONE_Q15) - qs);
         end
         default: wu = ONE_Q15;
      endcase
   end

   always_ff @(posedge clock) begin
      if (b_en[0]) begin
         for (int i = 0; i < 3; i++) begin
            m1_ff[i] <= PROD_W'(dcomp(div_out.side.e1, 2'(i)))
                      * PROD_W'($signed({1'b0, div_out.q1}));
            m2_ff[i] <= PROD_W'(dcomp(div_out.side.e2, 2'(i)))
                      * PROD_W'($signed({1'b0, div_out.q2}));
         end
         bs_ff <= div_out.side.base;
         rg_ff <= div_out.side.region;
         wu_ff <= wu;
         wv_ff <= wv;
         ww_ff <= ww;
      end
   end

   // ---------------------------------------------------------------
   // B1: round at 2^-15, add base corner, saturate
   // ---------------------------------------------------------------
   logic signed [SUM_W-1:0]   acc [3];
   logic signed [SUM_W-1:0]   pt  [3];
   logic signed [COORD_W-1:0] near [3];
   rsp_type                   rsp_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = SUM_W'(m1_ff[i]) + SUM_W'(m2_ff[i]) + RND_HALF;
         pt[i]  = (acc[i] >>> Q_FRAC) + SUM_W'(ccomp(bs_ff, 2'(i)));
         if (pt[i] > SAT_MAX) begin
            near[i] = SAT_MAX[COORD_W-1:0];
         end else if (pt[i] < SAT_MIN) begin
            near[i] = SAT_MIN[COORD_W-1:0];
         end else begin
            near[i] = pt[i][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_en[1]) begin
         rsp_ff.nearest_x     <= near[0];
         rsp_ff.nearest_y     <= near[1];
         rsp_ff.nearest_z     <= near[2];
         rsp_ff.weight_first  <= wu_ff;
         rsp_ff.weight_second <= wv_ff;
         rsp_ff.weight_third  <= ww_ff;
         rsp_ff.region        <= rg_ff;
      end
   end

   assign rsp_valid = b_vld_ff[1];
   assign rsp_data  = rsp_ff;

   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.region != RGN_FACE |->
         (Q_W+1)'(rsp_data.weight_first) + (Q_W+1)'(rsp_data.weight_second)
       + (Q_W+1)'(rsp_data.weight_third) == (Q_W+1)'(ONE_Q15))
      else $error("weights of a corner or edge result do not sum to 1.0");

   a_corner_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.region == RGN_A || rsp_data.region == RGN_B ||
                    rsp_data.region == RGN_C) |->
         $onehot({rsp_data.weight_first == ONE_Q15, rsp_data.weight_second == ONE_Q15,
                  rsp_data.weight_third == ONE_Q15}))
      else $error("corner result without a single full weight");

   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      f_vld_ff[5] && !div_in_ready |=>
         f_vld_ff[5] && $stable(va_ff) && $stable(vb_ff) && $stable(vc_ff))
      else $error("front stage lost its item while the divider stalled");

endmodule

>>> test/tb_closest_point_on_triangle.sv
`timescale 1ns / 100ps

module tb_closest_point_on_triangle;
   import cpt_pkg::*;

   localparam int LATENCY     = 24;
   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type pending_q[$];
   int      error_count = 0;
   int      result_count = 0;
   int      query_count = 0;
   int      region_seen[8];
   int      cycle_count = 0;
   bit      hold_off = 1'b0;
   bit      stall_enable = 1'b0;

   closest_point_on_triangle dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor: exact integer arithmetic at wide widths
   // ------------------------------------------------------------------
   typedef logic signed [95:0] wint;

   function automatic logic [15:0] q15_ratio(wint num, wint den);
      logic [15:0] q;
      wint         r;
      q = '0;
      r = num;
      if (num <= 0 || den <= 0) return '0;
      if (num >= den) return ONE_Q15;
      // restoring division, one bit at a time, then round half up
      for (int i = 0; i < 15; i++) begin
         r = r <<< 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
      end
      r = r <<< 1;
      if (r >= den) q = q + 1;
      return q;
   endfunction

   function automatic longint round_at_q15(longint x);
      longint y;
      y = x + 16384;
      return y >>> 15;   // arithmetic shift is a floor
   endfunction

   function automatic logic [15:0] clip16(longint x);
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
      return x[15:0];
   endfunction

   function automatic rsp_type nearest_feature(req_type r);
      longint p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
      longint e1[3], e2[3], base[3];
      longint d1, d2, d3, d4, d5, d6, cx, cy, cz;
      wint    va, vb, vc;
      longint s1, s2;
      logic [15:0] u, v, w;
      region_type rg;
      rsp_type res;
      p = '{r.query_x, r.query_y, r.query_z};
      a = '{r.corner_a_x, r.corner_a_y, r.corner_a_z};
      b = '{r.corner_b_x, r.corner_b_y, r.corner_b_z};
      c = '{r.corner_c_x, r.corner_c_y, r.corner_c_z};
      for (int i = 0; i < 3; i++) begin
         ab[i] = b[i] - a[i]; ac[i] = c[i] - a[i]; bc[i] = c[i] - b[i];
         ap[i] = p[i] - a[i]; bp[i] = p[i] - b[i]; cp[i] = p[i] - c[i];
         e1[i] = 0; e2[i] = 0; base[i] = a[i];
      end
      cx = ab[1] * ac[2] - ab[2] * ac[1];
      cy = ab[2] * ac[0] - ab[0] * ac[2];
      cz = ab[0] * ac[1] - ab[1] * ac[0];
      d1 = ab[0]*ap[0] + ab[1]*ap[1] + ab[2]*ap[2];
      d2 = ac[0]*ap[0] + ac[1]*ap[1] + ac[2]*ap[2];
      d3 = ab[0]*bp[0] + ab[1]*bp[1] + ab[2]*bp[2];
      d4 = ac[0]*bp[0] + ac[1]*bp[1] + ac[2]*bp[2];
      d5 = ab[0]*cp[0] + ab[1]*cp[1] + ab[2]*cp[2];
      d6 = ac[0]*cp[0] + ac[1]*cp[1] + ac[2]*cp[2];
      vc = wint'(d1) * wint'(d4) - wint'(d3) * wint'(d2);
      vb = wint'(d5) * wint'(d2) - wint'(d1) * wint'(d6);
      va = wint'(d3) * wint'(d6) - wint'(d5) * wint'(d4);
      u = ONE_Q15; v = '0; w = '0; s1 = 0; s2 = 0;
      if (cx == 0 && cy == 0 && cz == 0) begin
         rg = RGN_DEGEN;
      end else if (d1 <= 0 && d2 <= 0) begin
         rg = RGN_A;
      end else if (d3 >= 0 && d4 <= d3) begin
         rg = RGN_B; base = b; u = '0; v = ONE_Q15;
      end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
         rg = RGN_AB;
         v = q15_ratio(d1, d1 - d3); u = ONE_Q15 - v;
         e1 = ab; s1 = v;
      end else if (d6 >= 0 && d5 <= d6) begin
         rg = RGN_C; base = c; u = '0; w = ONE_Q15;
      end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
         rg = RGN_AC;
         w = q15_ratio(d2, d2 - d6); u = ONE_Q15 - w;
         e1 = ac; s1 = w;
      end else if (va <= 0 && (d4 - d3) >= 0 && (d5 - d6) >= 0) begin
         rg = RGN_BC; base = b;
         w = q15_ratio(d4 - d3, (d4 - d3) + (d5 - d6));
         u = '0; v = ONE_Q15 - w;
         e1 = bc; s1 = w;
      end else begin
         rg = RGN_FACE;
         v = q15_ratio(vb, va + vb + vc);
         w = q15_ratio(vc, va + vb + vc);
         u = (32'(v) + 32'(w) >= 32768) ? '0 : ONE_Q15 - v - w;
         e1 = ab; e2 = ac; s1 = v; s2 = w;
      end
      res.nearest_x = clip16(base[0] + round_at_q15(e1[0] * s1 + e2[0] * s2));
      res.nearest_y = clip16(base[1] + round_at_q15(e1[1] * s1 + e2[1] * s2));
      res.nearest_z = clip16(base[2] + round_at_q15(e1[2] * s1 + e2[2] * s2));
      res.weight_first = u;
      res.weight_second = v;
      res.weight_third = w;
      res.region = rg;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Reporting and checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at result %0d: %s got %0d expected %0d",
               result_count, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            want = pending_q.pop_front();
            if (rsp_data.nearest_x !== want.nearest_x)
               report_mismatch("nearest_x", rsp_data.nearest_x, want.nearest_x);
            if (rsp_data.nearest_y !== want.nearest_y)
               report_mismatch("nearest_y", rsp_data.nearest_y, want.nearest_y);
            if (rsp_data.nearest_z !== want.nearest_z)
               report_mismatch("nearest_z", rsp_data.nearest_z, want.nearest_z);
            if (rsp_data.weight_first !== want.weight_first)
               report_mismatch("weight_first", rsp_data.weight_first,
                               want.weight_first);
            if (rsp_data.weight_second !== want.weight_second)
               report_mismatch("weight_second", rsp_data.weight_second,
                               want.weight_second);
            if (rsp_data.weight_third !== want.weight_third)
               report_mismatch("weight_third", rsp_data.weight_third,
                               want.weight_third);
            if (rsp_data.region !== want.region)
               report_mismatch("region", rsp_data.region, want.region);
            region_seen[want.region]++;
         end
         result_count++;
      end
   end

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (hold_off)
         rsp_ready <= 1'b0;
      else if (!stall_enable)
         rsp_ready <= 1'b1;
      else if (r < 60)
         rsp_ready <= 1'b1;
      else if (r < 97)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(0, 3) == 0);
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   function automatic logic [15:0] rand_coord(int scale);
      case (scale)
         0: return 16'($urandom_range(0, 255)) - 16'd128;
         1: return 16'($urandom_range(0, 8191)) - 16'd4096;
         default: return 16'($urandom);
      endcase
   endfunction

   // Idle cycles before the next transfer: mostly none or short, a few long
   function automatic int gap_length();
      int r, n;
      r = $urandom_range(0, 99);
      if (r < 55) n = 0;
      else if (r < 95) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 40);
      return n;
   endfunction

   // Valid stays high between back-to-back transfers; it drops only for a gap or in drain
   task automatic send_query(req_type q, bit with_gap);
      int n;
      n = with_gap ? gap_length() : 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_q = {pending_q, nearest_feature(q)};
      query_count++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   function automatic req_type make_query(logic [15:0] v[12]);
      req_type q;
      q = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
      return q;
   endfunction

   // Random triangle and query point, at a random coordinate scale
   function automatic req_type random_query();
      logic [15:0] v[12];
      int scale;
      scale = $urandom_range(0, 9) < 4 ? 0 : ($urandom_range(0, 2) == 0 ? 2 : 1);
      for (int i = 0; i < 12; i++) v[i] = rand_coord(scale);
      // occasionally collapse the triangle or put the point on a corner
      case ($urandom_range(0, 19))
         0: begin v[6] = v[3]; v[7] = v[4]; v[8] = v[5]; end
         1: for (int i = 0; i < 3; i++) v[9 + i] = v[3 + i] + (v[6 + i] - v[3 + i]);
         2: for (int i = 0; i < 3; i++) v[i] = v[3 + 3 * $urandom_range(0, 2) + i];
         default: ;
      endcase
      return make_query(v);
   endfunction

   task automatic test_directed();
      logic [15:0] v[12];
      // right triangle in the xy plane, points placed in each region
      int pts[10][3] = '{
         '{-100, -100, 0}, '{1200, -50, 9}, '{500, -300, 0}, '{-40, 1500, -7},
         '{-300, 400, 0},  '{900, 900, 50}, '{200, 300, 100}, '{0, 0, 0},
         '{333, 333, -32768}, '{32767, 32767, 32767}};
      for (int k = 0; k < 10; k++) begin
         v = '{16'(pts[k][0]), 16'(pts[k][1]), 16'(pts[k][2]),
               16'd0, 16'd0, 16'd0, 16'd1000, 16'd0, 16'd0, 16'd0, 16'd1000, 16'd0};
         send_query(make_query(v), 1'b0);
      end
      // extreme corners, large triangle
      v = '{16'h8000, 16'h7fff, 16'h0000, 16'h8000, 16'h8000, 16'h8000,
            16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff};
      send_query(make_query(v), 1'b0);
      v = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000,
            16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h7fff};
      send_query(make_query(v), 1'b0);
      v = '{16'hffff, 16'h0001, 16'h5555, 16'haaaa, 16'h8000, 16'h7fff,
            16'h7fff, 16'h8000, 16'h8000, 16'h0000, 16'h7fff, 16'h8000};
      send_query(make_query(v), 1'b0);
      // degenerate: coincident corners, then collinear corners
      v = '{16'd5, 16'd6, 16'd7, 16'd10, 16'd10, 16'd10, 16'd10, 16'd10, 16'd10,
            16'd10, 16'd10, 16'd10};
      send_query(make_query(v), 1'b0);
      v = '{16'd5, 16'd6, 16'd7, 16'd0, 16'd0, 16'd0, 16'd100, 16'd200, 16'd300,
            16'd200, 16'd400, 16'd600};
      send_query(make_query(v), 1'b0);
      // point exactly on corner B, then on the middle of edge BC
      v = '{16'd1000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1000, 16'd0, 16'd0,
            16'd0, 16'd1000, 16'd0};
      send_query(make_query(v), 1'b0);
      v[0] = 16'd500; v[1] = 16'd500;
      send_query(make_query(v), 1'b0);
      drain();
   endtask

   task automatic test_random_stream(int n);
      stall_enable = 1'b1;
      for (int k = 0; k < n; k++)
         send_query(random_query(), $urandom_range(0, 3) != 0);
      drain();
   endtask

   // Back to back with no gaps or stalls: full rate
   task automatic test_full_rate(int n);
      stall_enable = 1'b0;
      for (int k = 0; k < n; k++) send_query(random_query(), 1'b0);
      drain();
   endtask

   // Receiver holds off long enough for the pipeline to fill and stall input
   task automatic test_backpressure(int n);
      int held;
      hold_off = 1'b1;
      fork
         begin
            held = 0;
            while (held < 3 * LATENCY) begin
               @(posedge clock);
               held++;
            end
            hold_off = 1'b0;
         end
         for (int k = 0; k < n; k++) send_query(random_query(), 1'b0);
      join
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_rate(100);
      test_backpressure(80);
      test_random_stream(1050);
      repeat (LATENCY + 10) @(posedge clock);
      $display("ran %0d queries, %0d results checked", query_count, result_count);
      $display("regions A/B/AB/C/AC/BC/face/degenerate: %0d %0d %0d %0d %0d %0d %0d %0d",
               region_seen[0], region_seen[1], region_seen[2], region_seen[3],
               region_seen[4], region_seen[5], region_seen[6], region_seen[7]);
      if (error_count == 0 && pending_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
